// File: src/rpba_pkg.sv
// ----------------------------------------------------------------------------
// rpba_pkg
// Shared types, widths and codes of the radial profile box average block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rpba_pkg;

   // table geometry
   localparam int TABLE_DEPTH     = 1024;
   localparam int MAX_HALF_WINDOW = 255;
   localparam int IDX_W   = $clog2(TABLE_DEPTH);
   localparam int SIZE_W  = $clog2(TABLE_DEPTH + 1);
   localparam int HW_W    = $clog2(MAX_HALF_WINDOW + 1);
   localparam int CNT_W   = $clog2(2 * MAX_HALF_WINDOW + 1);
   localparam int EXT_W   = ((IDX_W > HW_W) ? IDX_W : HW_W) + 2;

   // field widths
   localparam int VAL_W   = 16;
   localparam int RAD_W   = 18;
   localparam int INV_W   = 20;
   localparam int PROD_W  = RAD_W + INV_W;
   localparam int FRAC_W  = 24;
   localparam int Q_W     = PROD_W - FRAC_W;
   localparam int SUM_W   = VAL_W + CNT_W;
   localparam int STEP_W  = $clog2(SUM_W + 1);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;
   localparam int HWC_W   = 8;
   localparam int SZC_W   = 11;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OUTER_RADIUS       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_SPACING_BRIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_SPACING_TRANS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_WINDOW_BRIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_WINDOW_TRANS  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_USED_SIZE_BRIGHT   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_USED_SIZE_TRANS    = 3'd6;

   // action codes
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;
   localparam logic SEL_BRIGHT = 1'b0;

   typedef struct packed {
      logic              action;
      logic              table_sel;
      logic [9:0]        entry_index;
      logic [VAL_W-1:0]  entry_value;
      logic [RAD_W-1:0]  radius;
   } req_type;

   typedef struct packed {
      logic [VAL_W-1:0]  average;
      logic              in_range;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SUB,
      S_MUL,
      S_IDX,
      S_CHK,
      S_READ,
      S_DRAIN,
      S_DIVLD,
      S_DIV,
      S_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic sub_en;
      logic mul_en;
      logic idx_en;
      logic rd_en;
      logic div_ld;
      logic div_en;
      logic rsp_ld;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic idx_ok;
      logic rd_last;
      logic div_last;
      logic rsp_free;
   } status_type;

endpackage

// File: src/rpba_ctrl.sv
// ----------------------------------------------------------------------------
// rpba_ctrl
// Sequencer: index math, window read sweep, divide and result handoff.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpba_ctrl
   import rpba_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_query,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_query == ACT_QUERY) begin
                  state_in = S_SUB;
               end
            end
         end
         S_SUB: begin
            cmd.sub_en = 1'b1;
            state_in   = S_MUL;
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = S_IDX;
         end
         S_IDX: begin
            cmd.idx_en = 1'b1;
            state_in   = S_CHK;
         end
         S_CHK: begin
            state_in = status.idx_ok ? S_READ : S_DONE;
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            if (status.rd_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_DIVLD;
         end
         S_DIVLD: begin
            cmd.div_ld = 1'b1;
            state_in   = S_DIV;
         end
         S_DIV: begin
            cmd.div_en = 1'b1;
            if (status.div_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (status.rsp_free) begin
               cmd.rsp_ld = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: src/rpba_dpath.sv
// ----------------------------------------------------------------------------
// rpba_dpath
// Config registers, profile tables, index arithmetic, accumulator, divider
// and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpba_dpath
   import rpba_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  req_type               req_data,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  cmd_type               cmd,
   output status_type            status
);

   // config registers
   logic [RAD_W-1:0] outer_ff;
   logic [INV_W-1:0] inv_b_ff, inv_t_ff;
   logic [HWC_W-1:0] hw_b_ff, hw_t_ff;
   logic [SZC_W-1:0] size_b_ff, size_t_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         outer_ff  <= '0;
         inv_b_ff  <= INV_W'(256);
         inv_t_ff  <= INV_W'(256);
         hw_b_ff   <= HWC_W'(1);
         hw_t_ff   <= HWC_W'(1);
         size_b_ff <= SZC_W'(1024);
         size_t_ff <= SZC_W'(1024);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OUTER_RADIUS:       outer_ff  <= csr_wdata[RAD_W-1:0];
            CSR_INV_SPACING_BRIGHT: inv_b_ff  <= csr_wdata[INV_W-1:0];
            CSR_INV_SPACING_TRANS:  inv_t_ff  <= csr_wdata[INV_W-1:0];
            CSR_HALF_WINDOW_BRIGHT: hw_b_ff   <= csr_wdata[HWC_W-1:0];
            CSR_HALF_WINDOW_TRANS:  hw_t_ff   <= csr_wdata[HWC_W-1:0];
            CSR_USED_SIZE_BRIGHT:   size_b_ff <= csr_wdata[SZC_W-1:0];
            CSR_USED_SIZE_TRANS:    size_t_ff <= csr_wdata[SZC_W-1:0];
            default: ;
         endcase
      end
   end

   // captured query
   logic             sel_ff;
   logic [RAD_W-1:0] rad_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sel_ff <= req_data.table_sel;
         rad_ff <= req_data.radius;
      end
   end

   // profile tables, one write and one registered read each
   logic [VAL_W-1:0] bright_mem [TABLE_DEPTH];
   logic [VAL_W-1:0] trans_mem  [TABLE_DEPTH];
   logic [VAL_W-1:0] bright_q_ff, trans_q_ff;
   logic [IDX_W-1:0] ptr_ff;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;

   assign wr_en   = cmd.accept && (req_data.action == ACT_WRITE) &&
                    (32'(req_data.entry_index) < TABLE_DEPTH);
   assign wr_addr = IDX_W'(req_data.entry_index);

   always_ff @(posedge clock) begin
      if (wr_en && (req_data.table_sel == SEL_BRIGHT)) begin
         bright_mem[wr_addr] <= req_data.entry_value;
      end
      if (cmd.rd_en) begin
         bright_q_ff <= bright_mem[ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (req_data.table_sel != SEL_BRIGHT)) begin
         trans_mem[wr_addr] <= req_data.entry_value;
      end
      if (cmd.rd_en) begin
         trans_q_ff <= trans_mem[ptr_ff];
      end
   end

   // stage 1: signed distance magnitude and per-table parameters
   logic [RAD_W:0]    delta;
   logic [RAD_W-1:0]  mag_ff;
   logic              neg_ff;
   logic [INV_W-1:0]  inv_ff;
   logic [HW_W-1:0]   win_ff;
   logic [SIZE_W-1:0] size_ff;
   logic [HWC_W-1:0]  hw_sel;
   logic [SZC_W-1:0]  sz_sel;

   assign delta  = {1'b0, outer_ff} - {1'b0, rad_ff};
   assign hw_sel = (sel_ff == SEL_BRIGHT) ? hw_b_ff : hw_t_ff;
   assign sz_sel = (sel_ff == SEL_BRIGHT) ? size_b_ff : size_t_ff;

   always_ff @(posedge clock) begin
      if (cmd.sub_en) begin
         neg_ff <= delta[RAD_W];
         mag_ff <= delta[RAD_W] ? RAD_W'(-delta) : delta[RAD_W-1:0];
         inv_ff <= (sel_ff == SEL_BRIGHT) ? inv_b_ff : inv_t_ff;
         win_ff <= (32'(hw_sel) > MAX_HALF_WINDOW) ? HW_W'(MAX_HALF_WINDOW)
                                                   : HW_W'(hw_sel);
         size_ff <= (32'(sz_sel) > TABLE_DEPTH) ? SIZE_W'(TABLE_DEPTH)
                                                : SIZE_W'(sz_sel);
      end
   end

   // stage 2: scaled index product
   logic [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= PROD_W'(mag_ff) * PROD_W'(inv_ff);
      end
   end

   // stage 3: range check and window bounds
   logic [Q_W-1:0]   qidx;
   logic             out_rng;
   logic [IDX_W-1:0] idx;
   logic [EXT_W-1:0] idx_x, win_x, hi_x, lim_x, j1_x, j2_x, cnt_x;
   logic             ok_ff;
   logic [IDX_W-1:0] j2_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             acc_en_ff;
   logic [SUM_W-1:0] acc_ff;

   assign qidx    = prod_ff[PROD_W-1:FRAC_W];
   assign out_rng = (neg_ff && (qidx != '0)) || (32'(qidx) >= 32'(size_ff));
   assign idx     = qidx[IDX_W-1:0];
   assign idx_x   = EXT_W'(idx);
   assign win_x   = EXT_W'(win_ff);
   assign hi_x    = idx_x + win_x;
   assign lim_x   = EXT_W'(size_ff) - EXT_W'(1);
   assign j1_x    = (idx_x >= win_x) ? (idx_x - win_x) : '0;
   assign j2_x    = (hi_x > lim_x) ? lim_x : hi_x;
   assign cnt_x   = j2_x - j1_x;

   always_ff @(posedge clock) begin
      if (cmd.idx_en) begin
         ok_ff  <= !out_rng && (cnt_x != '0);
         j2_ff  <= j2_x[IDX_W-1:0];
         cnt_ff <= cnt_x[CNT_W-1:0];
      end
   end

   // window sweep pointer and accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_en_ff <= 1'b0;
      end else begin
         acc_en_ff <= cmd.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.idx_en) begin
         ptr_ff <= j1_x[IDX_W-1:0];
         acc_ff <= '0;
      end else begin
         if (cmd.rd_en) begin
            ptr_ff <= ptr_ff + IDX_W'(1);
         end
         if (acc_en_ff) begin
            acc_ff <= acc_ff + SUM_W'((sel_ff == SEL_BRIGHT) ? bright_q_ff
                                                             : trans_q_ff);
         end
      end
   end

   // restoring divider, one quotient bit per cycle
   logic [CNT_W-1:0]  rem_ff;
   logic [SUM_W-1:0]  quo_ff;
   logic [STEP_W-1:0] step_ff;
   logic [CNT_W:0]    trial;
   logic              fits;

   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign fits  = trial >= {1'b0, cnt_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_ld) begin
         rem_ff  <= '0;
         quo_ff  <= acc_ff;
         step_ff <= STEP_W'(SUM_W);
      end else if (cmd.div_en) begin
         rem_ff  <= fits ? CNT_W'(trial - {1'b0, cnt_ff}) : trial[CNT_W-1:0];
         quo_ff  <= {quo_ff[SUM_W-2:0], fits};
         step_ff <= step_ff - STEP_W'(1);
      end
   end

   // result register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_ld) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_ld) begin
         rsp_data_ff.average  <= ok_ff ? quo_ff[VAL_W-1:0] : '0;
         rsp_data_ff.in_range <= ok_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // status back to the sequencer
   assign status.idx_ok   = ok_ff;
   assign status.rd_last  = (EXT_W'(ptr_ff) + EXT_W'(1)) == EXT_W'(j2_ff);
   assign status.div_last = step_ff == STEP_W'(1);
   assign status.rsp_free = !rsp_valid_ff || !rsp_stall;

`ifndef SYNTHESIS
   // window reads only for an in-range query
   a_rd_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> ok_ff)
      else $error("table read for out-of-range query");

   // last table word summed before divider loads
   a_acc_done: assert property (@(posedge clock) disable iff (reset)
      cmd.div_ld |-> !acc_en_ff && !cmd.rd_en)
      else $error("divider loaded while accumulating");

   // result never overwrites an item still waiting
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_ld |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overrun");

   // mean of 16-bit entries fits in 16 bits
   a_quo_fit: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_ld && ok_ff) |-> (quo_ff[SUM_W-1:VAL_W] == '0))
      else $error("average overflow");
`endif

endmodule

// File: src/radial_profile_box_average.sv
// a table write is taken while idle; a query runs subtract, multiply, index,
//    check, a read sweep over cnt = window entries (2 * half window max),
//    drain, divider load, divide, handoff (out-of-range: check then handoff);
//    one query at a time, one entry read per cycle, 25-step bit-serial divider
// reset: synchronous, clears the sequencer, the result valid and the config
//    registers; table contents are undefined until written
// ----------------------------------------------------------------------------
// radial_profile_box_average
// Box average over a window of a brightness or transparency radial profile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module radial_profile_box_average
   import rpba_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   rpba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_query (req_data.action),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   rpba_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// File: tb/tb_radial_profile_box_average.sv
// ----------------------------------------------------------------------------
// tb_radial_profile_box_average
// Self-checking bench for the radial profile box average block. Table loads
// and radius queries stream in through a bursty driver while the result side
// stalls on its own pattern. Each query result is compared with a bench-side
// window average kept in step with every accepted item. Register settings
// change only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_radial_profile_box_average;
   import rpba_pkg::*;

   localparam int   NUM_REGS      = 7;
   localparam int   PHASE_ITEMS   = 72;
   localparam int   RANDOM_PHASES = 7;
   localparam int   DRAIN_CYCLES  = 600;
   localparam int   MAX_REPORTS   = 10;
   localparam logic SEL_TRANS     = ~SEL_BRIGHT;

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;

   // bench copy of the tables and registers
   logic [VAL_W-1:0]      profile_mem [2][TABLE_DEPTH];
   logic [CSR_DATA_W-1:0] reg_shadow [NUM_REGS];
   logic [CSR_DATA_W-1:0] reg_next [NUM_REGS];
   bit                    loaded [2][TABLE_DEPTH];

   req_type pending_q [$];
   rsp_type average_q [$];

   bit req_taken;
   int burst_left, gap_left, stall_run, free_run;
   int mismatch_count, items_accepted, averages_checked, in_range_count, phases_run;

   radial_profile_box_average u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("tb_radial_profile_box_average: errors");
      $finish;
   end

   // table window for a radius under the current settings; 0 when no result
   function automatic bit locate_window(input logic sel, input logic [RAD_W-1:0] rad,
                                        output int lo, output int hi);
      longint d, mag, q, size, win, inv;
      d    = longint'(reg_shadow[CSR_OUTER_RADIUS]) - longint'(rad);
      mag  = (d < 0) ? -d : d;
      inv  = (sel == SEL_BRIGHT) ? longint'(reg_shadow[CSR_INV_SPACING_BRIGHT])
                                 : longint'(reg_shadow[CSR_INV_SPACING_TRANS]);
      size = (sel == SEL_BRIGHT) ? longint'(reg_shadow[CSR_USED_SIZE_BRIGHT])
                                 : longint'(reg_shadow[CSR_USED_SIZE_TRANS]);
      win  = (sel == SEL_BRIGHT) ? longint'(reg_shadow[CSR_HALF_WINDOW_BRIGHT])
                                 : longint'(reg_shadow[CSR_HALF_WINDOW_TRANS]);
      q    = (mag * inv) >>> FRAC_W;
      lo   = 0;
      hi   = 0;
      if (size > TABLE_DEPTH) size = TABLE_DEPTH;
      if (win > MAX_HALF_WINDOW) win = MAX_HALF_WINDOW;
      // radius beyond the outer edge only survives when it rounds to entry 0
      if (d < 0 && q != 0) return 1'b0;
      if (q >= size) return 1'b0;
      lo = int'(q - win);
      hi = int'(q + win);
      if (lo < 0) lo = 0;
      if (hi >= size) hi = int'(size) - 1;
      return (hi - lo) > 0;
   endfunction

   // radius that lands on a chosen table index, random when unreachable
   function automatic logic [RAD_W-1:0] radius_for(input logic sel, input int target);
      longint inv, outer, d_lo, d_hi;
      outer = longint'(reg_shadow[CSR_OUTER_RADIUS]);
      inv   = (sel == SEL_BRIGHT) ? longint'(reg_shadow[CSR_INV_SPACING_BRIGHT])
                                  : longint'(reg_shadow[CSR_INV_SPACING_TRANS]);
      if (inv == 0) return RAD_W'($urandom_range(0, 18'h3FFFF));
      d_lo = ((longint'(target) << FRAC_W) + inv - 1) / inv;
      d_hi = ((longint'(target + 1) << FRAC_W) + inv - 1) / inv - 1;
      if (d_hi < d_lo) d_hi = d_lo;
      if (d_lo > outer) return RAD_W'($urandom_range(0, 18'h3FFFF));
      if (d_hi > outer) d_hi = outer;
      return RAD_W'(outer - longint'($urandom_range(32'(d_hi), 32'(d_lo))));
   endfunction

   // mostly aimed at the used part of the table, some just outside the edge
   function automatic logic [RAD_W-1:0] pick_radius(input logic sel);
      int size, roll;
      longint r;
      size = (sel == SEL_BRIGHT) ? int'(reg_shadow[CSR_USED_SIZE_BRIGHT])
                                 : int'(reg_shadow[CSR_USED_SIZE_TRANS]);
      if (size > TABLE_DEPTH) size = TABLE_DEPTH;
      roll = $urandom_range(0, 99);
      if (roll < 65) return radius_for(sel, $urandom_range(0, size + 1));
      if (roll < 75) begin
         r = longint'(reg_shadow[CSR_OUTER_RADIUS]) + $urandom_range(0, 300);
         return (r > 18'h3FFFF) ? 18'h3FFFF : RAD_W'(r);
      end
      return RAD_W'($urandom_range(0, 18'h3FFFF));
   endfunction

   task automatic queue_write(input logic sel, input int idx, input logic [VAL_W-1:0] val);
      req_type it;
      it.action      = ACT_WRITE;
      it.table_sel   = sel;
      it.entry_index = idx[9:0];
      it.entry_value = val;
      it.radius      = RAD_W'($urandom_range(0, 18'h3FFFF));
      pending_q.push_back(it);
      loaded[sel][idx] = 1'b1;
   endtask

   // load any window entry not yet written, then ask for the average
   task automatic queue_query(input logic sel, input logic [RAD_W-1:0] rad);
      req_type it;
      int lo, hi;
      if (locate_window(sel, rad, lo, hi)) begin
         for (int j = lo; j < hi; j++)
            if (!loaded[sel][j]) queue_write(sel, j, VAL_W'($urandom_range(0, 16'hFFFF)));
      end
      it.action      = ACT_QUERY;
      it.table_sel   = sel;
      it.entry_index = 10'($urandom_range(0, 1023));
      it.entry_value = VAL_W'($urandom_range(0, 16'hFFFF));
      it.radius      = rad;
      pending_q.push_back(it);
   endtask

   // write all registers from reg_next; junk fills the unused upper data bits
   task automatic program_regs(input bit junk);
      logic [CSR_DATA_W-1:0] w, m;
      int width;
      for (int r = 0; r < NUM_REGS; r++) begin
         case (CSR_IDX_W'(r))
            CSR_OUTER_RADIUS: width = RAD_W;
            CSR_INV_SPACING_BRIGHT, CSR_INV_SPACING_TRANS: width = INV_W;
            CSR_HALF_WINDOW_BRIGHT, CSR_HALF_WINDOW_TRANS: width = HWC_W;
            default: width = SZC_W;
         endcase
         m = CSR_DATA_W'((64'd1 << width) - 1);
         w = reg_next[r] & m;
         if (junk) w = w | (CSR_DATA_W'($urandom) & ~m);
         @(negedge clock);
         csr_we        <= 1'b1;
         csr_index     <= CSR_IDX_W'(r);
         csr_wdata     <= w;
         reg_shadow[r]  = w & m;
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // hold off until nothing is queued or outstanding, then let the block settle
   task automatic wait_idle();
      while (pending_q.size() != 0 || req_valid || average_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      phases_run++;
   endtask

   // request driver: bursts of items with random gaps
   always @(negedge clock) begin : drive_req
      logic    nv;
      req_type nd;
      nv = req_valid;
      nd = req_data;
      if (reset) begin
         nv = 1'b0;
      end else begin
         if (req_taken) begin
            nv        = 1'b0;
            req_taken = 1'b0;
         end
         if (!nv) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_q.size() != 0) begin
               nd = pending_q.pop_front();
               nv = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
      end
      req_valid <= nv;
      req_data  <= nd;
   end

   // result stall pattern: short blips, long holds and free stretches
   always @(negedge clock) begin : drive_stall
      logic ns;
      ns = 1'b0;
      if (!reset) begin
         if (stall_run > 0) begin
            stall_run--;
            ns = 1'b1;
         end else if (free_run > 0) begin
            free_run--;
         end else begin
            stall_run = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 3);
            free_run  = $urandom_range(0, 12);
         end
      end
      rsp_stall <= ns;
   end

   // accepted items update the bench tables; accepted results are checked
   always @(posedge clock) begin : observe
      rsp_type want;
      int      lo, hi;
      longint  sum;
      bit      ok;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            items_accepted++;
            if (req_data.action == ACT_WRITE) begin
               profile_mem[req_data.table_sel][req_data.entry_index] = req_data.entry_value;
            end else begin
               ok  = locate_window(req_data.table_sel, req_data.radius, lo, hi);
               sum = 0;
               if (ok)
                  for (int j = lo; j < hi; j++) sum += profile_mem[req_data.table_sel][j];
               want.in_range = ok;
               want.average  = ok ? VAL_W'(sum / (hi - lo)) : '0;
               average_q.push_back(want);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (average_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: result with no query outstanding: average %h in_range %b",
                           $realtime, rsp_data.average, rsp_data.in_range);
            end else begin
               want = average_q.pop_front();
               averages_checked++;
               if (want.in_range) in_range_count++;
               if (rsp_data.average !== want.average || rsp_data.in_range !== want.in_range) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("%0t: result mismatch: average %h/%h in_range %b/%b (exp/got)",
                              $realtime, want.average, rsp_data.average,
                              want.in_range, rsp_data.in_range);
               end
            end
         end
      end
   end

   // stimulus sequence
   initial begin
      logic sel;
      int   roll;
      reg_shadow[CSR_OUTER_RADIUS]       = '0;
      reg_shadow[CSR_INV_SPACING_BRIGHT] = 20'd256;
      reg_shadow[CSR_INV_SPACING_TRANS]  = 20'd256;
      reg_shadow[CSR_HALF_WINDOW_BRIGHT] = 20'd1;
      reg_shadow[CSR_HALF_WINDOW_TRANS]  = 20'd1;
      reg_shadow[CSR_USED_SIZE_BRIGHT]   = 20'd1024;
      reg_shadow[CSR_USED_SIZE_TRANS]    = 20'd1024;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: extreme values, radius on and just past the outer edge
      queue_write(SEL_BRIGHT, 0, 16'hFFFF);
      queue_write(SEL_BRIGHT, 1023, 16'h0000);
      queue_write(SEL_TRANS, 0, 16'h0000);
      queue_write(SEL_TRANS, 1023, 16'hFFFF);
      queue_query(SEL_BRIGHT, 18'h00000);
      queue_query(SEL_TRANS, 18'h0FFFF);
      queue_query(SEL_BRIGHT, 18'h10000);
      queue_query(SEL_TRANS, 18'h3FFFF);
      wait_idle();

      // widest window and finest spacing on one table, empty window on the other
      reg_next[CSR_OUTER_RADIUS]       = 20'h3FFFF;
      reg_next[CSR_INV_SPACING_BRIGHT] = 20'hFFFFF;
      reg_next[CSR_INV_SPACING_TRANS]  = 20'h00000;
      reg_next[CSR_HALF_WINDOW_BRIGHT] = 20'd255;
      reg_next[CSR_HALF_WINDOW_TRANS]  = 20'd0;
      reg_next[CSR_USED_SIZE_BRIGHT]   = 20'd1024;
      reg_next[CSR_USED_SIZE_TRANS]    = 20'd1;
      program_regs(1'b0);
      queue_query(SEL_BRIGHT, radius_for(SEL_BRIGHT, 0));
      queue_query(SEL_BRIGHT, radius_for(SEL_BRIGHT, 1023));
      queue_query(SEL_BRIGHT, radius_for(SEL_BRIGHT, 1024));
      queue_query(SEL_BRIGHT, radius_for(SEL_BRIGHT, 512));
      queue_query(SEL_TRANS, 18'h00000);
      queue_query(SEL_TRANS, 18'h3FFFF);
      wait_idle();

      // zero used size, oversized used size, zero inverse spacing, small negative offset
      reg_next[CSR_OUTER_RADIUS]       = 20'h00000;
      reg_next[CSR_INV_SPACING_BRIGHT] = 20'h00000;
      reg_next[CSR_INV_SPACING_TRANS]  = 20'hFFFFF;
      reg_next[CSR_HALF_WINDOW_BRIGHT] = 20'd1;
      reg_next[CSR_HALF_WINDOW_TRANS]  = 20'd255;
      reg_next[CSR_USED_SIZE_BRIGHT]   = 20'd0;
      reg_next[CSR_USED_SIZE_TRANS]    = 20'd2047;
      program_regs(1'b0);
      queue_query(SEL_BRIGHT, 18'h00000);
      queue_query(SEL_TRANS, 18'h00000);
      queue_query(SEL_TRANS, 18'h00001);
      queue_query(SEL_TRANS, 18'h00011);
      wait_idle();

      // random settings, each followed by a stream of loads and queries
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         reg_next[CSR_OUTER_RADIUS] = CSR_DATA_W'(($urandom_range(0, 3) == 0)
                                      ? $urandom_range(0, 18'h3FFFF)
                                      : $urandom_range(18'h10000, 18'h3FFFF));
         for (int t = 0; t < 2; t++) begin
            reg_next[CSR_INV_SPACING_BRIGHT + t] = CSR_DATA_W'(($urandom_range(0, 3) == 0)
                                                   ? $urandom_range(0, 20'hFFFFF)
                                                   : $urandom_range(1 << 12, 1 << 18));
            roll = $urandom_range(0, 9);
            reg_next[CSR_HALF_WINDOW_BRIGHT + t] = CSR_DATA_W'((roll < 6)
                                                 ? $urandom_range(1, 8)
                                                 : (roll < 8) ? $urandom_range(9, 64)
                                                 : (roll < 9) ? $urandom_range(65, 255) : 0);
            roll = $urandom_range(0, 19);
            reg_next[CSR_USED_SIZE_BRIGHT + t] = CSR_DATA_W'((roll < 3)
                                               ? $urandom_range(1, 4)
                                               : (roll < 16) ? $urandom_range(5, 1024)
                                               : (roll < 18) ? 1024
                                               : (roll < 19) ? 0 : $urandom_range(1025, 2047));
         end
         program_regs(1'b1);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            sel = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 99) < 60)
               queue_query(sel, pick_radius(sel));
            else
               queue_write(sel, $urandom_range(0, TABLE_DEPTH - 1),
                           VAL_W'($urandom_range(0, 16'hFFFF)));
         end
         wait_idle();
      end

      $display("%0d items accepted over %0d register settings", items_accepted, phases_run);
      $display("%0d averages checked, %0d in range and %0d flagged",
               averages_checked, in_range_count, averages_checked - in_range_count);
      if (mismatch_count == 0 && average_q.size() == 0) begin
         $display("tb_radial_profile_box_average: clean");
      end else begin
         $display("tb_radial_profile_box_average: errors");
      end
      $finish;
   end

endmodule
